@@ rtl/core/color_class_partition_macros.svh @@
// Assertion helpers shared by the core modules.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef COLOR_CLASS_PARTITION_MACROS_SVH
`define COLOR_CLASS_PARTITION_MACROS_SVH

// Same-cycle implication, checked only while out of reset.
`define CCP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("color_class_partition assertion failed");

// Next-cycle implication, checked only while out of reset.
`define CCP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("color_class_partition assertion failed");

`endif

@@ rtl/core/ccp_pkg.sv @@
package ccp_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int MEM_DEPTH = 2 ** (VIDX_W + 1);

	localparam int COLOR_W = 6;
	localparam int LABEL_W = 6;
	localparam int NCOL_W = 7;
	localparam int NUM_COLOR_CODES = 2 ** COLOR_W;
	localparam logic [NCOL_W-1:0] NUM_COLORS_RESET = 7'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// One loaded run waiting for emission.
	typedef struct packed {
		logic bank;
		logic [CNT_W-1:0] count;
	} job_t;

	// Color store write from the loading side.
	typedef struct packed {
		logic en;
		logic [VIDX_W:0] addr;
		logic [COLOR_W-1:0] color;
	} store_wr_t;

endpackage

@@ rtl/core/ccp_ifs.sv @@
interface ccp_in_if;
	logic valid;
	logic ready;
	logic [ccp_pkg::COLOR_W-1:0] vertex_color;
	logic is_last_vertex;
	modport source(output valid, vertex_color, is_last_vertex, input ready);
	modport sink(input valid, vertex_color, is_last_vertex, output ready);
endinterface

interface ccp_out_if;
	logic valid;
	logic ready;
	logic [ccp_pkg::LABEL_W-1:0] vertex_label;
	logic cell_end;
	logic run_last;
	logic none_selected;
	modport source(output valid, vertex_label, cell_end, run_last, none_selected, input ready);
	modport sink(input valid, vertex_label, cell_end, run_last, none_selected, output ready);
endinterface

interface ccp_cfg_if;
	logic valid;
	logic ready;
	logic [ccp_pkg::NCOL_W-1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

@@ rtl/core/color_class_partition.sv @@
// Stable partition of vertices by color. Vertices arrive on the vertex channel in
// label order, one transaction per cycle while ready is high; the first gets label
// 0. The transaction with is_last_vertex set closes the run. The block then emits on
// the result channel the labels grouped by color, colors 0 to num_colors-1,
// ascending labels within each color, with cell_end on the last label of each color
// and run_last on the final result. Vertices with a color at or above num_colors are
// skipped; when none remain one result with none_selected and run_last set is given.
// Up to 64 vertices are kept per run and later ones are dropped. For each run the
// color store is scanned once per effective color (num_colors capped at 64) through
// its single read port, and output stalls slow the emission. The store has two
// banks, so the next run can be loaded while the previous one is being emitted;
// loading stalls only when both banks hold runs whose final result has not yet
// reached the output register. num_colors (reset value 3) is written through the
// cfg channel, which is always ready, and must only be changed while the block is
// idle.
module color_class_partition (
	input  logic       clk,
	input  logic       arst_n,
	ccp_in_if.sink     vertex,
	ccp_cfg_if.sink    cfg,
	ccp_out_if.source  result
);

	// Write port into the color store, driven by the loading side.
	ccp_pkg::store_wr_t store_wr;

	// Run descriptors passing from the loading side to the emission side.
	logic job_push;
	ccp_pkg::job_t job_data;
	logic job_pop;
	ccp_pkg::job_t job_head;
	logic job_empty;

	// Pulses when a run has handed over its final result, freeing its bank.
	logic job_done;

	// The front counts labels, picks the bank and hands over one descriptor per run.
	ccp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vertex   (vertex),
		.store_wr (store_wr),
		.job_push (job_push),
		.job_data (job_data),
		.job_done (job_done)
	);

	// A two-entry queue lets loading and emission stall independently.
	ccp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_data),
		.pop       (job_pop),
		.head      (job_head),
		.empty     (job_empty)
	);

	// The back holds the color store and scans it once per color class.
	ccp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.store_wr  (store_wr),
		.job_head  (job_head),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job_done  (job_done),
		.cfg       (cfg),
		.result    (result)
	);

endmodule

@@ rtl/core/ccp_front.sv @@
`include "color_class_partition_macros.svh"

module ccp_front (
	input  logic                clk,
	input  logic                arst_n,
	ccp_in_if.sink              vertex,
	output ccp_pkg::store_wr_t  store_wr,
	output logic                job_push,
	output ccp_pkg::job_t       job_data,
	input  logic                job_done
);

	logic [ccp_pkg::CNT_W-1:0] count_q;
	logic bank_q;
	logic [ccp_pkg::QCNT_W-1:0] credits_q;
	logic accept;
	logic has_room;
	logic [ccp_pkg::CNT_W-1:0] count_next;

	// A bank may be loaded only while no pending or running job holds it.
	assign vertex.ready = (credits_q != '0);
	assign accept = vertex.valid && vertex.ready;
	assign has_room = (count_q < ccp_pkg::CNT_W'(ccp_pkg::MAX_VERTICES));
	assign count_next = has_room ? count_q + 1'b1 : count_q;

	assign store_wr.en = accept && has_room;
	assign store_wr.addr = {bank_q, count_q[ccp_pkg::VIDX_W-1:0]};
	assign store_wr.color = vertex.vertex_color;

	assign job_push = accept && vertex.is_last_vertex;
	assign job_data.bank = bank_q;
	assign job_data.count = count_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q <= 1'b0;
			credits_q <= ccp_pkg::QCNT_W'(ccp_pkg::QUEUE_DEPTH);
		end else begin
			if (accept) begin
				if (vertex.is_last_vertex) begin
					count_q <= '0;
					bank_q <= ~bank_q;
				end else begin
					count_q <= count_next;
				end
			end
			if (job_push && !job_done) begin
				credits_q <= credits_q - 1'b1;
			end else if (job_done && !job_push) begin
				credits_q <= credits_q + 1'b1;
			end
		end
	end

	`CCP_ASSERT_NOW(a_credit_range, 1'b1, credits_q <= ccp_pkg::QCNT_W'(ccp_pkg::QUEUE_DEPTH))

endmodule

@@ rtl/core/ccp_queue.sv @@
`include "color_class_partition_macros.svh"

module ccp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ccp_pkg::job_t push_data,
	input  logic          pop,
	output ccp_pkg::job_t head,
	output logic          empty
);

	ccp_pkg::job_t entry_q [ccp_pkg::QUEUE_DEPTH];
	logic [ccp_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ccp_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ccp_pkg::QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ccp_pkg::QPTR_W'(ccp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ccp_pkg::QPTR_W'(ccp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CCP_ASSERT_NOW(a_no_overflow, push && !pop, count_q != ccp_pkg::QCNT_W'(ccp_pkg::QUEUE_DEPTH))
	`CCP_ASSERT_NOW(a_no_underflow, pop, count_q != '0)

endmodule

@@ rtl/core/ccp_back.sv @@
`include "color_class_partition_macros.svh"

module ccp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ccp_pkg::store_wr_t store_wr,
	input  ccp_pkg::job_t      job_head,
	input  logic               job_empty,
	output logic               job_pop,
	output logic               job_done,
	ccp_cfg_if.sink            cfg,
	ccp_out_if.source          result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;

	logic [ccp_pkg::COLOR_W-1:0] mem [ccp_pkg::MEM_DEPTH];

	logic [1:0] state_q;
	logic [ccp_pkg::NCOL_W-1:0] num_colors_q;
	logic bank_q;
	logic [ccp_pkg::CNT_W-1:0] n_q;
	logic [ccp_pkg::NCOL_W-1:0] ncol_q;
	logic [ccp_pkg::COLOR_W-1:0] col_q;
	logic [ccp_pkg::VIDX_W-1:0] v_q;
	logic issuing_q;

	logic s1_valid_s1;
	logic [ccp_pkg::COLOR_W-1:0] color_s1;
	logic [ccp_pkg::COLOR_W-1:0] col_s1;
	logic [ccp_pkg::VIDX_W-1:0] v_s1;
	logic cend_s1;
	logic send_s1;

	logic p_valid_q;
	logic [ccp_pkg::VIDX_W-1:0] p_label_q;
	logic p_cend_q;

	logic o_valid_q;
	logic [ccp_pkg::LABEL_W-1:0] o_label_q;
	logic o_cend_q;
	logic o_last_q;
	logic o_none_q;

	logic out_free;
	logic s1_match;
	logic need_push;
	logic advance;
	logic issue;
	logic final_fire;
	logic push;
	logic v_last;
	logic col_last;
	logic [ccp_pkg::NCOL_W-1:0] ncol_eff;

	assign cfg.ready = 1'b1;

	// Every color code lies below 64, so larger counts behave like 64.
	assign ncol_eff = (num_colors_q > ccp_pkg::NCOL_W'(ccp_pkg::NUM_COLOR_CODES)) ?
		ccp_pkg::NCOL_W'(ccp_pkg::NUM_COLOR_CODES) : num_colors_q;

	assign v_last = (v_q == ccp_pkg::VIDX_W'(n_q - 1'b1));
	assign col_last = (col_q == ccp_pkg::COLOR_W'(ncol_q - 1'b1));

	assign out_free = !o_valid_q || result.ready;
	assign s1_match = s1_valid_s1 && (color_s1 == col_s1);
	assign need_push = s1_match && p_valid_q;
	assign advance = !s1_valid_s1 || !need_push || out_free;
	assign issue = (state_q == ST_SCAN) && issuing_q && advance;
	assign final_fire = (state_q == ST_FINAL) && out_free;
	assign push = (s1_valid_s1 && need_push && out_free) || final_fire;

	assign job_pop = (state_q == ST_IDLE) && !job_empty;
	assign job_done = final_fire;

	assign result.valid = o_valid_q;
	assign result.vertex_label = o_label_q;
	assign result.cell_end = o_cend_q;
	assign result.run_last = o_last_q;
	assign result.none_selected = o_none_q;

	always_ff @(posedge clk) begin
		if (store_wr.en) begin
			mem[store_wr.addr] <= store_wr.color;
		end
		if (issue) begin
			color_s1 <= mem[{bank_q, v_q}];
			col_s1 <= col_q;
			v_s1 <= v_q;
			cend_s1 <= v_last;
			send_s1 <= v_last && col_last;
		end
		if (s1_valid_s1 && advance && s1_match) begin
			p_label_q <= v_s1;
		end
		if (push) begin
			if (final_fire && !p_valid_q) begin
				o_label_q <= '0;
				o_cend_q <= 1'b0;
			end else begin
				o_label_q <= ccp_pkg::LABEL_W'(p_label_q);
				o_cend_q <= p_cend_q;
			end
			o_last_q <= final_fire;
			o_none_q <= final_fire && !p_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_colors_q <= ccp_pkg::NUM_COLORS_RESET;
			bank_q <= 1'b0;
			n_q <= '0;
			ncol_q <= '0;
			col_q <= '0;
			v_q <= '0;
			issuing_q <= 1'b0;
			s1_valid_s1 <= 1'b0;
			p_valid_q <= 1'b0;
			p_cend_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				num_colors_q <= cfg.data;
			end

			if (job_pop) begin
				bank_q <= job_head.bank;
				n_q <= job_head.count;
				ncol_q <= ncol_eff;
				col_q <= '0;
				v_q <= '0;
				issuing_q <= 1'b1;
				p_valid_q <= 1'b0;
				p_cend_q <= 1'b0;
				state_q <= (ncol_eff == '0) ? ST_FINAL : ST_SCAN;
			end

			if (issue) begin
				if (v_last) begin
					v_q <= '0;
					if (col_last) begin
						issuing_q <= 1'b0;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end else begin
					v_q <= v_q + 1'b1;
				end
			end

			if (advance) begin
				s1_valid_s1 <= issue;
			end

			// The held result learns whether it closes its cell only when the
			// scan of its color ends or the next match of that color turns up.
			if (s1_valid_s1 && advance) begin
				if (s1_match) begin
					p_valid_q <= 1'b1;
					p_cend_q <= cend_s1;
				end else if (cend_s1) begin
					p_cend_q <= 1'b1;
				end
				if (send_s1) begin
					state_q <= ST_FINAL;
				end
			end

			if (final_fire) begin
				state_q <= ST_IDLE;
			end

			if (push) begin
				o_valid_q <= 1'b1;
			end else if (result.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	`CCP_ASSERT_NOW(a_s1_only_in_scan, s1_valid_s1, state_q == ST_SCAN)
	`CCP_ASSERT_NEXT(a_final_after_done, job_done, state_q == ST_IDLE && o_valid_q && o_last_q)

endmodule

@@ bench/tb_color_class_partition.sv @@
`timescale 1ns / 100ps

module tb_color_class_partition;

	// One placement in the emitted partition, laid out as the result channel carries it.
	typedef struct packed {
		logic [ccp_pkg::LABEL_W-1:0] label;
		logic cell_end;
		logic run_last;
		logic none_selected;
	} placement_t;

	// The directed table mixes vertex transactions with writes of num_colors.
	typedef enum logic {
		ROW_VERTEX,
		ROW_CONFIG
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [ccp_pkg::NCOL_W-1:0] value;
		logic last;
		logic typed;
		placement_t want;
	} row_t;

	localparam int CLK_HALF_NS = 5;
	localparam int RESET_CYCLES = 3;
	// Settling time after the final placement, so that the block is fully idle.
	localparam int SETTLE_CYCLES = 16;
	localparam int VERTEX_TARGET = 450;
	// Overall time limit; the simulation is declared hung if it runs past it.
	localparam int LIMIT_NS = 10_000_000;

	// A run in which nothing qualifies produces this single placement.
	localparam placement_t EMPTY_RUN = '{label: '0, cell_end: 1'b0, run_last: 1'b1,
		none_selected: 1'b1};
	// A run whose only qualifying vertex is vertex 0.
	localparam placement_t SOLE_FIRST = '{label: '0, cell_end: 1'b1, run_last: 1'b1,
		none_selected: 1'b0};
	localparam placement_t NO_ENTRY = '0;

	// Directed stimulus. Rows with typed set carry their expected placement, which is
	// obvious from the row; all other rows are checked against the predictor below.
	localparam int NUM_ROWS = 19;
	localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
		// Reset value of num_colors is 3. A lone vertex of color 0 forms one cell.
		'{ROW_VERTEX, 7'd0, 1'b1, 1'b1, SOLE_FIRST},
		// The highest color is out of range, so nothing is selected.
		'{ROW_VERTEX, 7'd63, 1'b1, 1'b1, EMPTY_RUN},
		// A mixed run with every in-range color present.
		'{ROW_VERTEX, 7'd2, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd1, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd0, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd2, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd1, 1'b1, 1'b0, NO_ENTRY},
		// A color equal to num_colors is the first one left out.
		'{ROW_VERTEX, 7'd3, 1'b1, 1'b1, EMPTY_RUN},
		// With zero colors configured every run comes back empty.
		'{ROW_CONFIG, 7'd0, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd0, 1'b1, 1'b1, EMPTY_RUN},
		// Sixty-four colors admit every color code, including the highest.
		'{ROW_CONFIG, 7'd64, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd63, 1'b1, 1'b1, SOLE_FIRST},
		// The largest register value behaves like sixty-four. The two colors toggle
		// every bit of the color field.
		'{ROW_CONFIG, 7'd127, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd42, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd21, 1'b1, 1'b0, NO_ENTRY},
		// A single color class with a gap in the labels.
		'{ROW_CONFIG, 7'd1, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd0, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd5, 1'b0, 1'b0, NO_ENTRY},
		'{ROW_VERTEX, 7'd0, 1'b1, 1'b0, NO_ENTRY}
	};

	logic clk;
	logic arst_n;

	ccp_in_if vertex_ch ();
	ccp_cfg_if cfg_ch ();
	ccp_out_if result_ch ();

	color_class_partition dut (
		.clk(clk),
		.arst_n(arst_n),
		.vertex(vertex_ch),
		.cfg(cfg_ch),
		.result(result_ch)
	);

	// Predictor state: the colors of the run being loaded, how many are held, and
	// the num_colors value the block was last given.
	logic [ccp_pkg::COLOR_W-1:0] stored_colors [ccp_pkg::MAX_VERTICES];
	int stored_count;
	logic [ccp_pkg::NCOL_W-1:0] stored_num_colors;

	// Placements computed for the most recent closing vertex.
	placement_t run_entries [ccp_pkg::MAX_VERTICES];

	// Placements still owed by the block, oldest first.
	placement_t expected_placements [$];

	int errors;
	int vertices_sent;
	// When set, neither side inserts idle cycles.
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF_NS) clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("color_class_partition verification failed");
		$finish;
	end

	// Random idle length: mostly none, often a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Loads one vertex into the predicted store. On the closing vertex it fills
	// run_entries with the stable partition by color and returns how many there are.
	function automatic int load_vertex(input logic [ccp_pkg::COLOR_W-1:0] color,
		input logic last);
		int n;
		int found_at;
		int limit;
		n = 0;
		// A vertex beyond the store's capacity is dropped, even if it closes the run.
		if (stored_count < ccp_pkg::MAX_VERTICES) begin
			stored_colors[stored_count] = color;
			stored_count++;
		end
		if (!last)
			return 0;
		// Anything above the number of color codes admits every color.
		limit = (stored_num_colors > ccp_pkg::NUM_COLOR_CODES) ?
			ccp_pkg::NUM_COLOR_CODES : stored_num_colors;
		for (int col = 0; col < limit; col++) begin
			found_at = -1;
			for (int v = 0; v < stored_count; v++) begin
				if (stored_colors[v] == col) begin
					run_entries[n] = '{label: ccp_pkg::LABEL_W'(v), cell_end: 1'b0,
						run_last: 1'b0, none_selected: 1'b0};
					found_at = n;
					n++;
				end
			end
			// The last label of each non-empty color cell closes that cell.
			if (found_at >= 0)
				run_entries[found_at].cell_end = 1'b1;
		end
		if (n == 0) begin
			run_entries[0] = EMPTY_RUN;
			n = 1;
		end else begin
			run_entries[n-1].run_last = 1'b1;
		end
		stored_count = 0;
		return n;
	endfunction

	// Presents one vertex and waits for the block to take it. Valid stays high after
	// the transaction so that back-to-back vertices keep it asserted; it only drops
	// when a gap is inserted or the sender holds off.
	task automatic send_vertex(input logic [ccp_pkg::COLOR_W-1:0] color, input logic last,
		input logic typed, input placement_t typed_entry);
		int unsigned gap;
		int n;
		gap = pick_gap();
		if (gap != 0) begin
			vertex_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vertex_ch.valid <= 1'b1;
		vertex_ch.vertex_color <= color;
		vertex_ch.is_last_vertex <= last;
		do @(posedge clk); while (!vertex_ch.ready);
		n = load_vertex(color, last);
		if (typed)
			expected_placements.push_back(typed_entry);
		else
			for (int i = 0; i < n; i++)
				expected_placements.push_back(run_entries[i]);
		vertices_sent++;
	endtask

	// Stops sending and waits until every owed placement has come out, then lets the
	// block's tail latency pass so that it is fully idle.
	task automatic drain_results();
		vertex_ch.valid <= 1'b0;
		while (expected_placements.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes num_colors. Only called while the block is idle.
	task automatic write_num_colors(input logic [ccp_pkg::NCOL_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		stored_num_colors = value;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic report_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Compares one accepted result transaction against the oldest owed placement.
	task automatic check_placement(input placement_t got);
		placement_t want;
		if (expected_placements.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual label %0d cell_end %0b",
				$time, got.label, got.cell_end);
			$display("%0t:   run_last %0b none_selected %0b", $time, got.run_last,
				got.none_selected);
			return;
		end
		want = expected_placements.pop_front();
		report_field("vertex_label", want.label, got.label);
		report_field("cell_end", want.cell_end, got.cell_end);
		report_field("run_last", want.run_last, got.run_last);
		report_field("none_selected", want.none_selected, got.none_selected);
	endtask

	// Result side: samples the handshake with the values that held before the edge
	// and stalls the block at random.
	initial begin : result_sink
		int unsigned hold;
		placement_t got;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got = '{label: result_ch.vertex_label, cell_end: result_ch.cell_end,
					run_last: result_ch.run_last, none_selected: result_ch.none_selected};
				check_placement(got);
			end
			if (hold != 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int runs;
		int run_len;
		int limit;
		logic [ccp_pkg::COLOR_W-1:0] color;
		logic [ccp_pkg::NCOL_W-1:0] num_colors;

		errors = 0;
		vertices_sent = 0;
		quiet = 1'b0;
		stored_count = 0;
		stored_num_colors = ccp_pkg::NUM_COLORS_RESET;
		arst_n = 1'b0;
		vertex_ch.valid = 1'b0;
		vertex_ch.vertex_color = '0;
		vertex_ch.is_last_vertex = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A register write always waits for the block to go idle first.
		for (int i = 0; i < NUM_ROWS; i++) begin
			if (DIRECTED_ROWS[i].kind == ROW_CONFIG) begin
				drain_results();
				write_num_colors(DIRECTED_ROWS[i].value);
			end else begin
				send_vertex(DIRECTED_ROWS[i].value[ccp_pkg::COLOR_W-1:0],
					DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
			end
		end

		// Overflow the store: two vertices past capacity, the second of them closing
		// the run. Emission covers only the stored vertices, all of which qualify.
		drain_results();
		write_num_colors(ccp_pkg::NCOL_W'(ccp_pkg::NUM_COLOR_CODES));
		for (int i = 0; i < ccp_pkg::MAX_VERTICES + 2; i++)
			send_vertex(ccp_pkg::COLOR_W'($urandom_range(0, 63)),
				i == ccp_pkg::MAX_VERTICES + 1, 1'b0, NO_ENTRY);

		// Random phases. Each one settles num_colors and then sends several complete
		// runs, mostly short ones, with colors biased toward the admitted range so
		// that most runs produce real cells.
		while (vertices_sent < VERTEX_TARGET) begin
			drain_results();
			case ($urandom_range(0, 11))
				0: num_colors = '0;
				1: num_colors = 7'd1;
				2: num_colors = ccp_pkg::NCOL_W'(ccp_pkg::NUM_COLOR_CODES);
				3: num_colors = ccp_pkg::NCOL_W'($urandom_range(ccp_pkg::NUM_COLOR_CODES + 1,
					127));
				4: num_colors = 7'd127;
				5: num_colors = ccp_pkg::NCOL_W'($urandom_range(17, 63));
				default: num_colors = ccp_pkg::NCOL_W'($urandom_range(2, 16));
			endcase
			write_num_colors(num_colors);
			quiet = ($urandom_range(0, 4) == 0);
			limit = (num_colors > ccp_pkg::NUM_COLOR_CODES) ?
				ccp_pkg::NUM_COLOR_CODES : num_colors;
			runs = $urandom_range(2, 6);
			repeat (runs) begin
				case ($urandom_range(0, 19))
					0: run_len = $urandom_range(ccp_pkg::MAX_VERTICES - 4,
						ccp_pkg::MAX_VERTICES + 6);
					1, 2, 3: run_len = $urandom_range(11, 40);
					default: run_len = $urandom_range(1, 10);
				endcase
				for (int i = 0; i < run_len; i++) begin
					if (limit != 0 && $urandom_range(0, 9) < 7)
						color = ccp_pkg::COLOR_W'($urandom_range(0, limit - 1));
					else
						color = ccp_pkg::COLOR_W'($urandom_range(0, 63));
					send_vertex(color, i == run_len - 1, 1'b0, NO_ENTRY);
				end
				// Now and then the sender holds off until the whole backlog is delivered.
				if ($urandom_range(0, 5) == 0)
					drain_results();
			end
		end
		quiet = 1'b0;

		drain_results();
		if (errors == 0)
			$display("color_class_partition verification clean");
		else
			$display("color_class_partition verification failed");
		$finish;
	end

endmodule
